>>> rtl/srpc_pkg.sv
// shared types and constants for the sorted packet reorder cache
// no dependencies; used by the interfaces, front, back and top level
package srpc_pkg;

  localparam int SEQ_W = 31;
  localparam int MODE_W = 2;
  localparam int DEPTH_DEF = 32;
  localparam int HANDLE_BITS_DEF = 16;

  localparam logic [MODE_W-1:0] MODE_INSERT = 2'd0;
  localparam logic [MODE_W-1:0] MODE_FLUSH  = 2'd1;
  localparam logic [MODE_W-1:0] MODE_CLEAR  = 2'd2;

  typedef enum logic [1:0] {
    OP_INSERT,
    OP_FLUSH,
    OP_CLEAR,
    OP_NOP
  } op_t;

  typedef struct packed {
    op_t              op;
    logic [SEQ_W-1:0] seq;
    logic [SEQ_W-1:0] expected;
  } cmd_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_DISPATCH,
    ST_INS_RD,
    ST_INS_CMP,
    ST_INS_PUT,
    ST_FL_RD,
    ST_FL_CMP,
    ST_EM_RD,
    ST_EM_OUT,
    ST_RESP
  } state_t;

endpackage

>>> rtl/srpc_if.sv
// valid/ready channel interfaces for input items and result beats
// depends on srpc_pkg
interface srpc_in_if #(parameter int HANDLE_BITS = srpc_pkg::HANDLE_BITS_DEF);
  logic                           valid;
  logic                           ready;
  logic [srpc_pkg::MODE_W-1:0]    mode;
  logic [srpc_pkg::SEQ_W-1:0]     seq;
  logic [HANDLE_BITS-1:0]         packet_handle;
  logic [srpc_pkg::SEQ_W-1:0]     expected;
  modport source (output valid, mode, seq, packet_handle, expected, input ready);
  modport sink (input valid, mode, seq, packet_handle, expected, output ready);
endinterface

interface srpc_out_if #(parameter int HANDLE_BITS = srpc_pkg::HANDLE_BITS_DEF);
  logic                           valid;
  logic                           ready;
  logic                           packet_valid;
  logic [HANDLE_BITS-1:0]         out_handle;
  logic [srpc_pkg::SEQ_W-1:0]     new_expected;
  logic                           overflow;
  logic                           last;
  modport source (output valid, packet_valid, out_handle, new_expected, overflow, last,
                  input ready);
  modport sink (input valid, packet_valid, out_handle, new_expected, overflow, last,
                output ready);
endinterface

>>> rtl/sorted_packet_reorder_cache.sv
// sorted packet reorder cache: clear, full insert and empty flush go straight to the result;
// insert compares entries on the walk down from the tail, shifting larger ones up; flush
// scans entries from the head, then pops the run as one beat per entry, or gives a single
// result beat when nothing pops. a 2-deep command queue lets new items in meanwhile.
// synchronous reset empties the store and the queue; store contents are not cleared.
// depends on srpc_pkg, srpc_if, srpc_front, srpc_back
module sorted_packet_reorder_cache #(
  parameter int DEPTH = srpc_pkg::DEPTH_DEF,
  parameter int HANDLE_BITS = srpc_pkg::HANDLE_BITS_DEF
) (
  input logic        clk,
  input logic        rst,
  srpc_in_if.sink    pkt_in,
  srpc_out_if.source pkt_out
);

  logic                   cmd_valid;
  logic                   cmd_pop;
  srpc_pkg::cmd_t         cmd;
  logic [HANDLE_BITS-1:0] cmd_handle;

  srpc_front #(.HANDLE_BITS(HANDLE_BITS)) u_front (
    .clk(clk), .rst(rst), .pkt_in(pkt_in),
    .cmd_valid(cmd_valid), .cmd_pop(cmd_pop), .cmd(cmd), .cmd_handle(cmd_handle)
  );

  srpc_back #(.DEPTH(DEPTH), .HANDLE_BITS(HANDLE_BITS)) u_back (
    .clk(clk), .rst(rst),
    .cmd_valid(cmd_valid), .cmd_pop(cmd_pop), .cmd(cmd), .cmd_handle(cmd_handle),
    .pkt_out(pkt_out)
  );

  a_pop_needs_cmd: assert property (@(posedge clk) disable iff (rst)
    cmd_pop |-> cmd_valid) else $error("queue popped while empty");

  a_accept_queues: assert property (@(posedge clk) disable iff (rst)
    pkt_in.valid && pkt_in.ready |=> cmd_valid) else $error("accepted beat not queued");

  a_ovf_alone: assert property (@(posedge clk) disable iff (rst)
    pkt_out.valid && pkt_out.overflow |-> !pkt_out.packet_valid && pkt_out.last)
    else $error("overflow beat malformed");

endmodule

>>> rtl/srpc_front.sv
// front end: accepts input beats, decodes the mode and queues commands
// depends on srpc_pkg and srpc_in_if
module srpc_front #(
  parameter int HANDLE_BITS = srpc_pkg::HANDLE_BITS_DEF
) (
  input  logic                   clk,
  input  logic                   rst,
  srpc_in_if.sink                pkt_in,
  output logic                   cmd_valid,
  input  logic                   cmd_pop,
  output srpc_pkg::cmd_t         cmd,
  output logic [HANDLE_BITS-1:0] cmd_handle
);

  srpc_pkg::cmd_t         q_cmd [2];
  logic [HANDLE_BITS-1:0] q_handle [2];
  logic                   wr_ptr;
  logic                   rd_ptr;
  logic [1:0]             fill;
  srpc_pkg::op_t          op_dec;
  logic                   push;

  always_comb begin
    case (pkt_in.mode)
      srpc_pkg::MODE_INSERT: op_dec = srpc_pkg::OP_INSERT;
      srpc_pkg::MODE_FLUSH:  op_dec = srpc_pkg::OP_FLUSH;
      srpc_pkg::MODE_CLEAR:  op_dec = srpc_pkg::OP_CLEAR;
      default:               op_dec = srpc_pkg::OP_NOP;
    endcase
  end

  assign pkt_in.ready = (fill != 2'd2);
  assign push = pkt_in.valid && pkt_in.ready;
  assign cmd_valid = (fill != 2'd0);
  assign cmd = q_cmd[rd_ptr];
  assign cmd_handle = q_handle[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      q_cmd[wr_ptr] <= '{op: op_dec, seq: pkt_in.seq, expected: pkt_in.expected};
      q_handle[wr_ptr] <= pkt_in.packet_handle;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      fill <= 2'd0;
    end else begin
      if (push) wr_ptr <= ~wr_ptr;
      if (cmd_pop) rd_ptr <= ~rd_ptr;
      case ({push, cmd_pop})
        2'b10:   fill <= fill + 2'd1;
        2'b01:   fill <= fill - 2'd1;
        default: fill <= fill;
      endcase
    end
  end

endmodule

>>> rtl/srpc_back.sv
// back end: sorted circular store in memory, insert/flush sequencer, result register
// depends on srpc_pkg and srpc_out_if
module srpc_back #(
  parameter int DEPTH = srpc_pkg::DEPTH_DEF,
  parameter int HANDLE_BITS = srpc_pkg::HANDLE_BITS_DEF
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   cmd_valid,
  output logic                   cmd_pop,
  input  srpc_pkg::cmd_t         cmd,
  input  logic [HANDLE_BITS-1:0] cmd_handle,
  srpc_out_if.source             pkt_out
);

  localparam int AW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);
  localparam int SW = srpc_pkg::SEQ_W;

  logic [SW-1:0]          mem_seq [DEPTH];
  logic [HANDLE_BITS-1:0] mem_handle [DEPTH];

  srpc_pkg::state_t state, state_next;
  logic [AW-1:0]  head, head_next;
  logic [CW-1:0]  count, count_next;
  logic [CW-1:0]  k, k_next;
  logic [CW-1:0]  n, n_next;
  logic [SW-1:0]  run, run_next;
  logic           res_ovf, res_ovf_next;
  srpc_pkg::cmd_t         c_cmd;
  logic [HANDLE_BITS-1:0] c_handle;

  logic                   rd_en, wr_en;
  logic [AW-1:0]          rd_addr, wr_addr;
  logic [SW-1:0]          wr_seq, rd_seq;
  logic [HANDLE_BITS-1:0] wr_handle, rd_handle;

  logic                   o_valid, o_pv, o_ovf, o_last;
  logic [HANDLE_BITS-1:0] o_handle;
  logic [SW-1:0]          o_nexp;
  logic                   o_free, o_load, o_pv_d, o_ovf_d, o_last_d;
  logic [HANDLE_BITS-1:0] o_handle_d;
  logic [SW-1:0]          o_nexp_d;

  // logical slot to physical address in the circular store
  function automatic logic [AW-1:0] phys(input logic [AW-1:0] base, input logic [CW-1:0] off);
    logic [CW:0] s;
    s = (CW+1)'(base) + (CW+1)'(off);
    if (s >= (CW+1)'(DEPTH)) s = s - (CW+1)'(DEPTH);
    return s[AW-1:0];
  endfunction

  assign o_free = !o_valid || pkt_out.ready;

  // next state
  always_comb begin
    state_next = state;
    case (state)
      srpc_pkg::ST_IDLE: if (cmd_valid) state_next = srpc_pkg::ST_DISPATCH;
      srpc_pkg::ST_DISPATCH: begin
        case (c_cmd.op)
          srpc_pkg::OP_INSERT: begin
            if (count == CW'(DEPTH)) state_next = srpc_pkg::ST_RESP;
            else if (count == '0) state_next = srpc_pkg::ST_INS_PUT;
            else state_next = srpc_pkg::ST_INS_RD;
          end
          srpc_pkg::OP_FLUSH: begin
            if (count == '0) state_next = srpc_pkg::ST_RESP;
            else state_next = srpc_pkg::ST_FL_RD;
          end
          default: state_next = srpc_pkg::ST_RESP;
        endcase
      end
      srpc_pkg::ST_INS_RD: state_next = srpc_pkg::ST_INS_CMP;
      srpc_pkg::ST_INS_CMP: begin
        if (rd_seq > c_cmd.seq && k != CW'(1)) state_next = srpc_pkg::ST_INS_RD;
        else state_next = srpc_pkg::ST_INS_PUT;
      end
      srpc_pkg::ST_INS_PUT: state_next = srpc_pkg::ST_RESP;
      srpc_pkg::ST_FL_RD: state_next = srpc_pkg::ST_FL_CMP;
      srpc_pkg::ST_FL_CMP: begin
        if (rd_seq <= run) begin
          if (k + CW'(1) == count) state_next = srpc_pkg::ST_EM_RD;
          else state_next = srpc_pkg::ST_FL_RD;
        end else if (k == '0) begin
          state_next = srpc_pkg::ST_RESP;
        end else begin
          state_next = srpc_pkg::ST_EM_RD;
        end
      end
      srpc_pkg::ST_EM_RD: state_next = srpc_pkg::ST_EM_OUT;
      srpc_pkg::ST_EM_OUT: begin
        if (o_free) begin
          if (k + CW'(1) == n) state_next = srpc_pkg::ST_IDLE;
          else state_next = srpc_pkg::ST_EM_RD;
        end
      end
      srpc_pkg::ST_RESP: if (o_free) state_next = srpc_pkg::ST_IDLE;
      default: state_next = srpc_pkg::ST_IDLE;
    endcase
  end

  // datapath control
  always_comb begin
    head_next = head;
    count_next = count;
    k_next = k;
    n_next = n;
    run_next = run;
    res_ovf_next = res_ovf;
    cmd_pop = 1'b0;
    rd_en = 1'b0;
    rd_addr = phys(head, k);
    wr_en = 1'b0;
    wr_addr = phys(head, k);
    wr_seq = c_cmd.seq;
    wr_handle = c_handle;
    o_load = 1'b0;
    o_pv_d = 1'b0;
    o_handle_d = '0;
    o_nexp_d = '0;
    o_ovf_d = 1'b0;
    o_last_d = 1'b1;
    case (state)
      srpc_pkg::ST_IDLE: cmd_pop = cmd_valid;
      srpc_pkg::ST_DISPATCH: begin
        res_ovf_next = 1'b0;
        case (c_cmd.op)
          srpc_pkg::OP_INSERT: begin
            res_ovf_next = (count == CW'(DEPTH));
            k_next = count;
          end
          srpc_pkg::OP_FLUSH: begin
            run_next = c_cmd.expected + SW'(1);
            k_next = '0;
          end
          srpc_pkg::OP_CLEAR: count_next = '0;
          default: count_next = count;
        endcase
      end
      srpc_pkg::ST_INS_RD: begin
        rd_en = 1'b1;
        rd_addr = phys(head, k - CW'(1));
      end
      srpc_pkg::ST_INS_CMP: begin
        // shift larger entries up one slot while walking down from the tail
        if (rd_seq > c_cmd.seq) begin
          wr_en = 1'b1;
          wr_seq = rd_seq;
          wr_handle = rd_handle;
          k_next = k - CW'(1);
        end
      end
      srpc_pkg::ST_INS_PUT: begin
        wr_en = 1'b1;
        count_next = count + CW'(1);
      end
      srpc_pkg::ST_FL_RD: rd_en = 1'b1;
      srpc_pkg::ST_FL_CMP: begin
        if (rd_seq <= run) begin
          if (rd_seq == run) run_next = run + SW'(1);
          if (k + CW'(1) == count) begin
            n_next = k + CW'(1);
            k_next = '0;
          end else begin
            k_next = k + CW'(1);
          end
        end else begin
          n_next = k;
          k_next = '0;
        end
      end
      srpc_pkg::ST_EM_RD: rd_en = 1'b1;
      srpc_pkg::ST_EM_OUT: begin
        if (o_free) begin
          o_load = 1'b1;
          o_pv_d = 1'b1;
          o_handle_d = rd_handle;
          o_nexp_d = run;
          o_last_d = (k + CW'(1) == n);
          k_next = k + CW'(1);
          if (k + CW'(1) == n) begin
            head_next = phys(head, n);
            count_next = count - n;
          end
        end
      end
      srpc_pkg::ST_RESP: begin
        if (o_free) begin
          o_load = 1'b1;
          o_ovf_d = res_ovf;
          o_nexp_d = (c_cmd.op == srpc_pkg::OP_FLUSH) ? run : '0;
        end
      end
      default: cmd_pop = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_seq[wr_addr] <= wr_seq;
      mem_handle[wr_addr] <= wr_handle;
    end
    if (rd_en) begin
      rd_seq <= mem_seq[rd_addr];
      rd_handle <= mem_handle[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd_pop) begin
      c_cmd <= cmd;
      c_handle <= cmd_handle;
    end
    k <= k_next;
    n <= n_next;
    run <= run_next;
    res_ovf <= res_ovf_next;
    if (o_load) begin
      o_pv <= o_pv_d;
      o_handle <= o_handle_d;
      o_nexp <= o_nexp_d;
      o_ovf <= o_ovf_d;
      o_last <= o_last_d;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= srpc_pkg::ST_IDLE;
      head <= '0;
      count <= '0;
      o_valid <= 1'b0;
    end else begin
      state <= state_next;
      head <= head_next;
      count <= count_next;
      if (o_load) o_valid <= 1'b1;
      else if (pkt_out.ready) o_valid <= 1'b0;
    end
  end

  assign pkt_out.valid = o_valid;
  assign pkt_out.packet_valid = o_pv;
  assign pkt_out.out_handle = o_handle;
  assign pkt_out.new_expected = o_nexp;
  assign pkt_out.overflow = o_ovf;
  assign pkt_out.last = o_last;

endmodule

>>> tb/srpc_checker.sv
// result checker for the sorted packet reorder cache: watches both channels,
// keeps its own sorted store and compares every result beat; depends on srpc_pkg, srpc_if
`timescale 1ns / 100ps
module srpc_checker (
  input logic  clk,
  input logic  rst,
  srpc_in_if   pkt_in,
  srpc_out_if  pkt_out,
  output int   errors,
  output int   pending,
  output int   beats_seen
);

  typedef struct packed {
    logic                      packet_valid;
    logic [15:0]               out_handle;
    logic [srpc_pkg::SEQ_W-1:0] new_expected;
    logic                      overflow;
    logic                      last;
  } beat_t;

  localparam int STORE_DEPTH = 32;

  logic [srpc_pkg::SEQ_W-1:0] held_seq[$];
  logic [15:0]                held_handle[$];
  beat_t                      expected_beats[$];

  function automatic beat_t make_beat(logic pv, logic [15:0] h,
                                      logic [srpc_pkg::SEQ_W-1:0] ne, logic ov, logic lst);
    beat_t b;
    b.packet_valid = pv;
    b.out_handle = h;
    b.new_expected = ne;
    b.overflow = ov;
    b.last = lst;
    return b;
  endfunction

  task automatic apply_item(logic [srpc_pkg::MODE_W-1:0] mode,
                            logic [srpc_pkg::SEQ_W-1:0] seq,
                            logic [15:0] handle, logic [srpc_pkg::SEQ_W-1:0] exp_in);
    int pos;
    int n;
    logic [srpc_pkg::SEQ_W-1:0] run;
    logic [15:0] popped[$];
    if (mode == srpc_pkg::MODE_INSERT) begin
      if (held_seq.size() >= STORE_DEPTH) begin
        expected_beats.push_back(make_beat(0, 0, 0, 1, 1));
      end else begin
        pos = 0;
        while (pos < held_seq.size() && held_seq[pos] <= seq) pos++;
        held_seq.insert(pos, seq);
        held_handle.insert(pos, handle);
        expected_beats.push_back(make_beat(0, 0, 0, 0, 1));
      end
    end else if (mode == srpc_pkg::MODE_FLUSH) begin
      run = exp_in + 1'b1;
      while (held_seq.size() > 0 && held_seq[0] <= run) begin
        if (held_seq[0] == run) run = run + 1'b1;
        popped.push_back(held_handle.pop_front());
        void'(held_seq.pop_front());
      end
      n = popped.size();
      if (n == 0) expected_beats.push_back(make_beat(0, 0, run, 0, 1));
      for (int i = 0; i < n; i++)
        expected_beats.push_back(make_beat(1, popped[i], run, 0, i == n - 1));
    end else begin
      if (mode == srpc_pkg::MODE_CLEAR) begin
        held_seq.delete();
        held_handle.delete();
      end
      expected_beats.push_back(make_beat(0, 0, 0, 0, 1));
    end
  endtask

  assign pending = expected_beats.size();

  always @(posedge clk) begin
    beat_t got;
    beat_t want;
    if (rst) begin
      errors <= 0;
      beats_seen <= 0;
    end else begin
      if (pkt_in.valid && pkt_in.ready)
        apply_item(pkt_in.mode, pkt_in.seq, pkt_in.packet_handle, pkt_in.expected);
      if (pkt_out.valid && pkt_out.ready) begin
        beats_seen <= beats_seen + 1;
        got = make_beat(pkt_out.packet_valid, pkt_out.out_handle, pkt_out.new_expected,
                        pkt_out.overflow, pkt_out.last);
        if (expected_beats.size() == 0) begin
          $display("%0t: unexpected beat, expected none, actual %h", $time, got);
          errors <= errors + 1;
        end else begin
          want = expected_beats.pop_front();
          if (got !== want) begin
            $display("%0t: beat mismatch expected pv=%b h=%h ne=%h ov=%b last=%b",
                     $time, want.packet_valid, want.out_handle, want.new_expected,
                     want.overflow, want.last);
            $display("%0t:                actual pv=%b h=%h ne=%h ov=%b last=%b",
                     $time, got.packet_valid, got.out_handle, got.new_expected,
                     got.overflow, got.last);
            errors <= errors + 1;
          end
        end
      end
    end
  end
endmodule

>>> tb/testbench.sv
// stimulus and verdict for the sorted packet reorder cache
// depends on srpc_pkg, srpc_if, the block and srpc_checker
`timescale 1ns / 100ps
module testbench;

  localparam int CYCLE_LIMIT = 400000;
  localparam int SW = srpc_pkg::SEQ_W;

  logic clk = 0;
  logic rst = 1;
  logic calm = 0;
  int   errors, pending, beats_seen;
  int   cycles = 0;
  int   n_ins = 0, n_flush = 0, n_clear = 0;
  logic [SW-1:0] base_seq = 0;

  srpc_in_if  pkt_in();
  srpc_out_if pkt_out();

  sorted_packet_reorder_cache dut (.clk(clk), .rst(rst), .pkt_in(pkt_in), .pkt_out(pkt_out));
  srpc_checker chk (.clk(clk), .rst(rst), .pkt_in(pkt_in), .pkt_out(pkt_out),
                    .errors(errors), .pending(pending), .beats_seen(beats_seen));

  always #1 clk = ~clk;

  initial begin
    pkt_in.valid = 0;
    pkt_in.mode = srpc_pkg::MODE_INSERT;
    pkt_in.seq = 0;
    pkt_in.packet_handle = 0;
    pkt_in.expected = 0;
    pkt_out.ready = 0;
  end

  // sink stalls about 28 in 100 except during the calm stretch
  always @(posedge clk) begin
    if (rst) pkt_out.ready <= 0;
    else pkt_out.ready <= calm || ($urandom_range(99) >= 28);
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycles);
      $display("FAIL sorted_packet_reorder_cache");
      $finish;
    end
  end

  task automatic send(logic [srpc_pkg::MODE_W-1:0] mode, logic [SW-1:0] seq,
                      logic [15:0] handle, logic [SW-1:0] exp_in);
    while (!calm && $urandom_range(99) < 28) begin
      pkt_in.valid <= 0;
      @(posedge clk);
    end
    pkt_in.valid <= 1;
    pkt_in.mode <= mode;
    pkt_in.seq <= seq;
    pkt_in.packet_handle <= handle;
    pkt_in.expected <= exp_in;
    @(posedge clk);
    while (!pkt_in.ready) @(posedge clk);
    if (mode == srpc_pkg::MODE_INSERT) n_ins++;
    else if (mode == srpc_pkg::MODE_FLUSH) n_flush++;
    else if (mode == srpc_pkg::MODE_CLEAR) n_clear++;
  endtask

  // one window: a run of inserts around a base, then a flush that catches most of it
  task automatic window_burst();
    int cnt;
    cnt = $urandom_range(1, 12);
    for (int i = 0; i < cnt; i++)
      send(srpc_pkg::MODE_INSERT, base_seq + SW'($urandom_range(0, 2 * cnt)),
           16'($urandom), 0);
    send(srpc_pkg::MODE_FLUSH, 0, 16'($urandom), base_seq - 1'b1);
    base_seq = base_seq + SW'(cnt) + SW'($urandom_range(0, 3));
  endtask

  initial begin
    repeat (7) @(posedge clk);
    rst <= 0;
    @(posedge clk);

    // directed: empty flush, wrap, duplicates, extremes, unused mode, overflow
    send(srpc_pkg::MODE_FLUSH, 0, 0, 0);
    send(srpc_pkg::MODE_FLUSH, '1, 16'hffff, 31'h7ffffffe);
    send(srpc_pkg::MODE_INSERT, 31'h7fffffff, 16'hffff, 0);
    send(srpc_pkg::MODE_INSERT, 0, 16'h0001, 0);
    send(srpc_pkg::MODE_INSERT, 0, 16'h0002, 0);
    send(srpc_pkg::MODE_INSERT, 2, 16'h0003, 0);
    send(srpc_pkg::MODE_INSERT, 5, 16'h0004, 0);
    send(srpc_pkg::OP_NOP, 31'h55555555, 16'haaaa, 31'h2aaaaaaa);
    send(srpc_pkg::MODE_FLUSH, 0, 0, 31'h7ffffffe);
    send(srpc_pkg::MODE_FLUSH, 0, 0, 31'h7ffffffd);
    send(srpc_pkg::MODE_FLUSH, 0, 0, 3);
    for (int i = 0; i < 33; i++)
      send(srpc_pkg::MODE_INSERT, 31'h40000000 - SW'(i), 16'(i), 0);
    send(srpc_pkg::MODE_CLEAR, 31'h7fffffff, 16'hffff, 31'h7fffffff);
    send(srpc_pkg::MODE_FLUSH, 0, 0, 0);

    // random: mostly well-formed windows, some noise, a calm stretch
    base_seq = SW'($urandom);
    for (int w = 0; w < 52; w++) begin
      calm = (w >= 18 && w < 26);
      if ($urandom_range(9) < 7) window_burst();
      else case ($urandom_range(3))
        0: send(srpc_pkg::MODE_INSERT, SW'($urandom), 16'($urandom), 0);
        1: send(srpc_pkg::MODE_FLUSH, 0, 16'($urandom), SW'($urandom_range(0, 31'h7ffffffe)));
        2: send(srpc_pkg::MODE_CLEAR, SW'($urandom), 16'($urandom), SW'($urandom));
        default: send(srpc_pkg::OP_NOP, SW'($urandom), 16'($urandom), SW'($urandom));
      endcase
    end
    calm = 0;
    pkt_in.valid <= 0;

    while (pending != 0) @(posedge clk);
    repeat (200) @(posedge clk);
    $display("run: %0d inserts, %0d flushes, %0d clears, %0d result beats checked",
             n_ins, n_flush, n_clear, beats_seen);
    if (errors == 0) $display("PASS sorted_packet_reorder_cache");
    else $display("FAIL sorted_packet_reorder_cache");
    $finish;
  end
endmodule

>>> files.f
rtl/srpc_pkg.sv
rtl/srpc_if.sv
rtl/srpc_front.sv
rtl/srpc_back.sv
rtl/sorted_packet_reorder_cache.sv
tb/srpc_checker.sv
tb/testbench.sv
